>>> sv/pegl_pkg.sv
package pegl_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int GAIN_W    = 22;
	localparam int FRAC_W    = 16;
	localparam int PEAK_W    = 17;
	localparam int COEFF_W   = 16;
	localparam int STEP_W    = 17;
	localparam int ENV_W     = 24;
	localparam int CFG_W     = 22;
	localparam int IDX_W     = 3;
	localparam int DIV_SHIFT = 23;
	localparam int QUO_W     = GAIN_W + 1;

	localparam int ENV_STEPS = COEFF_W;
	localparam int DIV_STEPS = PEAK_W + DIV_SHIFT;
	localparam int MUL_STEPS = GAIN_W;
	localparam int CNT_W     = 6;

	localparam logic [GAIN_W-1:0]   GAIN_ONE   = 22'd65536;
	localparam logic [GAIN_W-1:0]   GAIN_CEIL  = 22'd3276800;
	localparam logic [PEAK_W-1:0]   PEAK_LOW   = 17'd3277;
	localparam logic [PEAK_W-1:0]   PEAK_HIGH  = 17'd65536;
	localparam logic [ENV_W-1:0]    ENV_FLOOR  = 24'd838;
	localparam logic [ENV_W-1:0]    ENV_FULL   = 24'd8388608;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7fffff;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

	localparam logic [GAIN_W-1:0]  RST_MAX_GAIN = 22'd655360;
	localparam logic [PEAK_W-1:0]  RST_PEAK     = 17'd32768;
	localparam logic [COEFF_W-1:0] RST_RELEASE  = 16'd65533;
	localparam logic [STEP_W-1:0]  RST_RAISE    = 17'd33;
	localparam logic [STEP_W-1:0]  RST_FALL     = 17'd66;

	typedef enum logic [IDX_W-1:0] {
		REG_MAX_GAIN,
		REG_PEAK_TARGET,
		REG_RELEASE,
		REG_RAISE,
		REG_FALL
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_ENV,
		ST_ENV_END,
		ST_DIV,
		ST_TARGET,
		ST_GAIN,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} ser_ctl_t;

endpackage

>>> sv/pegl_env_mul.sv
module pegl_env_mul (
	input  logic                         clk,
	input  pegl_pkg::ser_ctl_t           ctl,
	input  logic [pegl_pkg::COEFF_W-1:0] coeff,
	input  logic [pegl_pkg::ENV_W-1:0]   diff,
	output logic [pegl_pkg::ENV_W-1:0]   prod_hi
);
	import pegl_pkg::*;

	logic [ENV_W-1:0]   acc_q;
	logic [COEFF_W-1:0] c_q;
	logic [ENV_W:0]     sum;

	// shift-add, low product bits drop off each step
	assign sum = {1'b0, acc_q} + (c_q[0] ? {1'b0, diff} : '0);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= '0;
			c_q   <= coeff;
		end else if (ctl.step) begin
			acc_q <= sum[ENV_W:1];
			c_q   <= c_q >> 1;
		end
	end

	assign prod_hi = acc_q;

endmodule

>>> sv/pegl_div.sv
module pegl_div (
	input  logic                        clk,
	input  pegl_pkg::ser_ctl_t          ctl,
	input  logic [pegl_pkg::PEAK_W-1:0] peak,
	input  logic [pegl_pkg::ENV_W-1:0]  divisor,
	output logic [pegl_pkg::QUO_W-1:0]  quo,
	output logic                        ovf
);
	import pegl_pkg::*;

	logic [ENV_W-1:0]  rem_q;
	logic [PEAK_W-1:0] dvd_q;
	logic [QUO_W-1:0]  quo_q;
	logic              ovf_q;
	logic [ENV_W:0]    trial;
	logic [ENV_W:0]    diff;
	logic              ge;

	// restoring divide, one quotient bit per step
	assign trial = {rem_q, dvd_q[PEAK_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			dvd_q <= peak;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.step) begin
			rem_q <= ge ? diff[ENV_W-1:0] : trial[ENV_W-1:0];
			dvd_q <= {dvd_q[PEAK_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[QUO_W-1];
		end
	end

	assign quo = quo_q;
	assign ovf = ovf_q;

endmodule

>>> sv/pegl_sample_mul.sv
module pegl_sample_mul (
	input  logic                          clk,
	input  pegl_pkg::ser_ctl_t            ctl,
	input  logic signed [pegl_pkg::SAMPLE_W-1:0] sample,
	input  logic [pegl_pkg::GAIN_W-1:0]   gain,
	output logic signed [pegl_pkg::SAMPLE_W-1:0] result
);
	import pegl_pkg::*;

	localparam int HI_W   = SAMPLE_W + 2;
	localparam int PROD_W = HI_W + GAIN_W;
	localparam int TOP_W  = PROD_W - (FRAC_W + SAMPLE_W - 1);

	logic signed [HI_W-1:0] hi_q;
	logic [GAIN_W-1:0]      lo_q;
	logic [GAIN_W-1:0]      g_q;
	logic signed [HI_W-1:0] sum;
	logic [PROD_W-1:0]      rnd;
	logic [TOP_W-1:0]       top;

	// signed accumulate, arithmetic shift right one gain bit per step
	assign sum = hi_q + (g_q[0] ? {{(HI_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample} : '0);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hi_q <= '0;
			lo_q <= '0;
			g_q  <= gain;
		end else if (ctl.step) begin
			hi_q <= {sum[HI_W-1], sum[HI_W-1:1]};
			lo_q <= {sum[0], lo_q[GAIN_W-1:1]};
			g_q  <= g_q >> 1;
		end
	end

	// round half up, then saturate
	assign rnd = {hi_q, lo_q} + (PROD_W'(1) << (FRAC_W - 1));
	assign top = rnd[PROD_W-1:FRAC_W+SAMPLE_W-1];

	always_comb begin
		if ((&top) || !(|top)) begin
			result = rnd[FRAC_W+SAMPLE_W-1:FRAC_W];
		end else if (top[TOP_W-1]) begin
			result = SAMPLE_MIN;
		end else begin
			result = SAMPLE_MAX;
		end
	end

endmodule

>>> sv/peak_envelope_gain_leveler_top.sv
// items are taken one at a time: a new item is accepted only after the last
// result is loaded into the output register; the bit-serial units run in turn:
//   16 envelope multiply steps, 40 divide steps, 22 output multiply steps
// a finished result waits in the output register while the next item runs
// reset: envelope 0, applied gain 1.0, registers to their default values
module peak_envelope_gain_leveler_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [pegl_pkg::SAMPLE_W-1:0] sample_left,
	input  logic signed [pegl_pkg::SAMPLE_W-1:0] sample_right,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pegl_pkg::SAMPLE_W-1:0] out_left,
	output logic signed [pegl_pkg::SAMPLE_W-1:0] out_right,
	output logic [pegl_pkg::GAIN_W-1:0]          gain_now,
	input  logic                                 cfg_we,
	input  logic [pegl_pkg::IDX_W-1:0]           cfg_index,
	input  logic [pegl_pkg::CFG_W-1:0]           cfg_data
);
	import pegl_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic [GAIN_W-1:0]  max_gain_q;
	logic [PEAK_W-1:0]  peak_q;
	logic [COEFF_W-1:0] release_q;
	logic [STEP_W-1:0]  raise_q;
	logic [STEP_W-1:0]  fall_q;

	logic signed [SAMPLE_W-1:0] samp_l_q, samp_r_q;
	logic [ENV_W-1:0]  m_q, diff_q, env_q;
	logic              up_q;
	logic [GAIN_W-1:0] target_q, gain_q, gain_d;
	logic              out_valid_q;
	logic signed [SAMPLE_W-1:0] out_l_q, out_r_q;
	logic [GAIN_W-1:0] out_g_q;

	ser_ctl_t env_ctl, div_ctl, mul_ctl;
	logic in_take, out_load;

	logic [ENV_W-1:0]  abs_l, abs_r, mag;
	logic [ENV_W-1:0]  env_part;
	logic [QUO_W-1:0]  quo;
	logic              quo_ovf;
	logic [GAIN_W-1:0] gmax_eff, target_d, up_gap, down_gap;
	logic [PEAK_W-1:0] peak_eff;
	logic signed [SAMPLE_W-1:0] res_l, res_r;

	// config clamps
	always_comb begin
		if (max_gain_q < GAIN_ONE) begin
			gmax_eff = GAIN_ONE;
		end else if (max_gain_q > GAIN_CEIL) begin
			gmax_eff = GAIN_CEIL;
		end else begin
			gmax_eff = max_gain_q;
		end
		if (peak_q < PEAK_LOW) begin
			peak_eff = PEAK_LOW;
		end else if (peak_q > PEAK_HIGH) begin
			peak_eff = PEAK_HIGH;
		end else begin
			peak_eff = peak_q;
		end
	end

	// frame magnitude, 2^23 fits as unsigned
	assign abs_l = samp_l_q[SAMPLE_W-1] ? ENV_W'(-samp_l_q) : ENV_W'(samp_l_q);
	assign abs_r = samp_r_q[SAMPLE_W-1] ? ENV_W'(-samp_r_q) : ENV_W'(samp_r_q);
	assign mag   = (abs_l > abs_r) ? abs_l : abs_r;

	always_comb begin
		if (env_q <= ENV_FLOOR) begin
			target_d = GAIN_ONE;
		end else if (quo_ovf || (quo > {1'b0, gmax_eff})) begin
			target_d = gmax_eff;
		end else if (quo[GAIN_W-1:0] < GAIN_ONE) begin
			target_d = GAIN_ONE;
		end else begin
			target_d = quo[GAIN_W-1:0];
		end
	end

	// gain walks toward the target by a limited step
	assign up_gap   = target_q - gain_q;
	assign down_gap = gain_q - target_q;

	always_comb begin
		if (target_q > gain_q) begin
			gain_d = (up_gap < {{(GAIN_W-STEP_W){1'b0}}, raise_q}) ?
				target_q : gain_q + {{(GAIN_W-STEP_W){1'b0}}, raise_q};
		end else begin
			gain_d = (down_gap < {{(GAIN_W-STEP_W){1'b0}}, fall_q}) ?
				target_q : gain_q - {{(GAIN_W-STEP_W){1'b0}}, fall_q};
		end
	end

	assign in_take  = in_valid && !in_stall;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_stall = 1'b1;
		env_ctl  = '0;
		div_ctl  = '0;
		mul_ctl  = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				env_ctl.load = 1'b1;
				cnt_d        = '0;
				state_d      = ST_ENV;
			end
			ST_ENV: begin
				env_ctl.step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ENV_STEPS - 1)) begin
					state_d = ST_ENV_END;
				end
			end
			ST_ENV_END: begin
				div_ctl.load = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				div_ctl.step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_TARGET;
				end
			end
			ST_TARGET: begin
				state_d = ST_GAIN;
			end
			ST_GAIN: begin
				mul_ctl.load = 1'b1;
				cnt_d        = '0;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				mul_ctl.step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gain_q <= RST_MAX_GAIN;
			peak_q     <= RST_PEAK;
			release_q  <= RST_RELEASE;
			raise_q    <= RST_RAISE;
			fall_q     <= RST_FALL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_GAIN:    max_gain_q <= cfg_data;
				REG_PEAK_TARGET: peak_q     <= cfg_data[PEAK_W-1:0];
				REG_RELEASE:     release_q  <= cfg_data[COEFF_W-1:0];
				REG_RAISE:       raise_q    <= cfg_data[STEP_W-1:0];
				REG_FALL:        fall_q     <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q       <= '0;
			gain_q      <= GAIN_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_ENV_END) begin
				env_q <= up_q ? m_q : m_q + env_part;
			end
			if (state_q == ST_GAIN) begin
				gain_q <= gain_d;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			samp_l_q <= sample_left;
			samp_r_q <= sample_right;
		end
		if (state_q == ST_PREP) begin
			m_q    <= mag;
			up_q   <= mag > env_q;
			diff_q <= env_q - mag;
		end
		if (state_q == ST_TARGET) begin
			target_q <= target_d;
		end
		if (out_load) begin
			out_l_q <= res_l;
			out_r_q <= res_r;
			out_g_q <= gain_q;
		end
	end

	pegl_env_mul u_env_mul (
		.clk     (clk),
		.ctl     (env_ctl),
		.coeff   (release_q),
		.diff    (diff_q),
		.prod_hi (env_part)
	);

	pegl_div u_div (
		.clk     (clk),
		.ctl     (div_ctl),
		.peak    (peak_eff),
		.divisor (env_q),
		.quo     (quo),
		.ovf     (quo_ovf)
	);

	pegl_sample_mul u_mul_l (
		.clk    (clk),
		.ctl    (mul_ctl),
		.sample (samp_l_q),
		.gain   (gain_d),
		.result (res_l)
	);

	pegl_sample_mul u_mul_r (
		.clk    (clk),
		.ctl    (mul_ctl),
		.sample (samp_r_q),
		.gain   (gain_d),
		.result (res_r)
	);

	assign out_valid = out_valid_q;
	assign out_left  = out_l_q;
	assign out_right = out_r_q;
	assign gain_now  = out_g_q;

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(gain_q >= GAIN_ONE) && (gain_q <= GAIN_CEIL))
		else $error("applied gain out of range");

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= ENV_FULL)
		else $error("envelope above full scale");

	a_gain_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (gain_now == gain_q))
		else $error("reported gain differs from applied gain");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_PREP))
		else $error("accepted item did not start processing");

endmodule

>>> tb/leveler_monitor.sv
`timescale 1ns / 1ps
module leveler_monitor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [pegl_pkg::SAMPLE_W-1:0] sample_left,
	input  logic signed [pegl_pkg::SAMPLE_W-1:0] sample_right,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [pegl_pkg::SAMPLE_W-1:0] out_left,
	input  logic signed [pegl_pkg::SAMPLE_W-1:0] out_right,
	input  logic [pegl_pkg::GAIN_W-1:0]          gain_now,
	input  logic                                 cfg_we,
	input  logic [pegl_pkg::IDX_W-1:0]           cfg_index,
	input  logic [pegl_pkg::CFG_W-1:0]           cfg_data,
	output int                                   fail_count,
	output int                                   frames_waiting,
	output int                                   frames_checked
);
	import pegl_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic [GAIN_W-1:0]          gain;
	} leveled_frame_t;

	logic [GAIN_W-1:0]  max_gain_r;
	logic [PEAK_W-1:0]  peak_r;
	logic [COEFF_W-1:0] release_r;
	logic [STEP_W-1:0]  raise_r;
	logic [STEP_W-1:0]  fall_r;
	logic [ENV_W-1:0]   envelope;
	logic [GAIN_W-1:0]  gain_state;

	leveled_frame_t expected_frames[$];
	int fails;
	int checked;

	function automatic longint scale_sample(input longint s, input longint g);
		longint q;
		longint hi;
		longint lo;
		hi = longint'($signed(SAMPLE_MAX));
		lo = longint'($signed(SAMPLE_MIN));
		// round half up, then floor shift
		q = (s * g + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
		if (q > hi) q = hi;
		if (q < lo) q = lo;
		return q;
	endfunction

	function automatic leveled_frame_t level_frame(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		longint sl;
		longint sr;
		longint mag;
		longint env;
		longint gmax;
		longint pk;
		longint target;
		longint g;
		longint d;
		leveled_frame_t res;
		sl = l;
		sr = r;
		mag = (sl < 0) ? -sl : sl;
		if (((sr < 0) ? -sr : sr) > mag) mag = (sr < 0) ? -sr : sr;

		// peak hold, else one-pole decay toward the magnitude
		env = envelope;
		if (mag > env) env = mag;
		else env = mag + ((longint'(release_r) * (env - mag)) >>> COEFF_W);
		envelope = ENV_W'(env);

		gmax = max_gain_r;
		if (gmax < longint'(GAIN_ONE)) gmax = GAIN_ONE;
		if (gmax > longint'(GAIN_CEIL)) gmax = GAIN_CEIL;
		pk = peak_r;
		if (pk < longint'(PEAK_LOW)) pk = PEAK_LOW;
		if (pk > longint'(PEAK_HIGH)) pk = PEAK_HIGH;

		if (env > longint'(ENV_FLOOR)) begin
			target = (pk <<< DIV_SHIFT) / env;
			if (target < longint'(GAIN_ONE)) target = GAIN_ONE;
			if (target > gmax) target = gmax;
		end else begin
			target = GAIN_ONE;
		end

		// slew-limited walk toward the target
		g = gain_state;
		if (target > g) begin
			d = target - g;
			g = g + ((d < longint'(raise_r)) ? d : longint'(raise_r));
		end else begin
			d = g - target;
			g = g - ((d < longint'(fall_r)) ? d : longint'(fall_r));
		end
		gain_state = GAIN_W'(g);

		res.left  = SAMPLE_W'(scale_sample(sl, longint'(gain_state)));
		res.right = SAMPLE_W'(scale_sample(sr, longint'(gain_state)));
		res.gain  = gain_state;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		leveled_frame_t want;
		if (!arst_n) begin
			max_gain_r = RST_MAX_GAIN;
			peak_r     = RST_PEAK;
			release_r  = RST_RELEASE;
			raise_r    = RST_RAISE;
			fall_r     = RST_FALL;
			envelope   = '0;
			gain_state = GAIN_ONE;
			expected_frames.delete();
			fails   = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_GAIN:    max_gain_r = cfg_data[GAIN_W-1:0];
					REG_PEAK_TARGET: peak_r     = cfg_data[PEAK_W-1:0];
					REG_RELEASE:     release_r  = cfg_data[COEFF_W-1:0];
					REG_RAISE:       raise_r    = cfg_data[STEP_W-1:0];
					REG_FALL:        fall_r     = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_frames.push_back(level_frame(sample_left, sample_right));
			if (out_valid && !out_stall) begin
				if (expected_frames.size() == 0) begin
					$error("result item with no frame pending: %s %0d %0d %0d",
						"out_left out_right gain_now", out_left, out_right, gain_now);
					fails++;
				end else begin
					want = expected_frames.pop_front();
					checked++;
					if (out_left !== want.left) begin
						$error("out_left: expected %0d, got %0d", want.left, out_left);
						fails++;
					end
					if (out_right !== want.right) begin
						$error("out_right: expected %0d, got %0d", want.right, out_right);
						fails++;
					end
					if (gain_now !== want.gain) begin
						$error("gain_now: expected %0d, got %0d", want.gain, gain_now);
						fails++;
					end
				end
			end
		end
		fail_count     <= fails;
		frames_waiting <= expected_frames.size();
		frames_checked <= checked;
	end

endmodule

>>> tb/peak_envelope_gain_leveler_top_test.sv
`timescale 1ns / 1ps
module peak_envelope_gain_leveler_top_test;
	import pegl_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 7;
	localparam int RANDOM_PHASES = 13;
	localparam int PHASE_FRAMES  = 98;
	localparam int HOLD_PHASE    = 6;
	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 200;
	localparam int CYCLE_LIMIT   = 2500000;

	typedef enum int {
		STYLE_SCALED,
		STYLE_MONO,
		STYLE_RAW,
		STYLE_CORNER
	} frame_style_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_left;
	logic signed [SAMPLE_W-1:0] sample_right;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] out_left;
	logic signed [SAMPLE_W-1:0] out_right;
	logic [GAIN_W-1:0]          gain_now;
	logic                       cfg_we;
	logic [IDX_W-1:0]           cfg_index;
	logic [CFG_W-1:0]           cfg_data;

	int fail_count;
	int frames_waiting;
	int frames_checked;
	int frames_sent;
	int settings_used;
	int cycle_count = 0;
	logic long_hold_req;
	logic sender_no_gaps;
	int level_shift;
	frame_style_t frame_style;

	peak_envelope_gain_leveler_top dut (.*);

	leveler_monitor monitor (.*);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d frames still pending",
				cycle_count, frames_waiting);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 8);
		if (r < 98) return $urandom_range(9, 40);
		return $urandom_range(41, 150);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] corner_sample();
		case ($urandom_range(0, 4))
			0: return $signed(SAMPLE_MAX);
			1: return $signed(SAMPLE_MIN);
			2: return '0;
			3: return 1;
			default: return -1;
		endcase
	endfunction

	// program level runs: quiet and loud stretches, mono, raw noise, corners
	task automatic next_frame(output logic signed [SAMPLE_W-1:0] l,
			output logic signed [SAMPLE_W-1:0] r);
		if ($urandom_range(0, 15) == 0) begin
			level_shift = $urandom_range(0, SAMPLE_W - 1);
			frame_style = frame_style_t'($urandom_range(0, 3));
		end
		l = $signed(SAMPLE_W'($urandom)) >>> (SAMPLE_W - 1 - level_shift);
		r = $signed(SAMPLE_W'($urandom)) >>> (SAMPLE_W - 1 - level_shift);
		case (frame_style)
			STYLE_MONO: r = l;
			STYLE_RAW: begin
				l = SAMPLE_W'($urandom);
				r = SAMPLE_W'($urandom);
			end
			STYLE_CORNER: begin
				l = corner_sample();
				r = corner_sample();
			end
			default: ;
		endcase
	endtask

	task automatic offer_frame(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		int gap;
		in_valid     <= 1'b1;
		sample_left  <= l;
		sample_right <= r;
		do @(posedge clk); while (in_stall);
		frames_sent++;
		gap = sender_no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (frames_waiting != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [CFG_W-1:0] gmax, input logic [CFG_W-1:0] pk,
			input logic [CFG_W-1:0] rc, input logic [CFG_W-1:0] rs,
			input logic [CFG_W-1:0] fs);
		write_reg(REG_MAX_GAIN, gmax);
		write_reg(REG_PEAK_TARGET, pk);
		write_reg(REG_RELEASE, rc);
		write_reg(REG_RAISE, rs);
		write_reg(REG_FALL, fs);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int len;
		bit hold_done;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 200)) @(posedge clk);
				len = pick_gap();
				if (len > 0) begin
					out_stall <= 1'b1;
					repeat (len) @(posedge clk);
				end
			end
		end
	end

	initial begin
		logic signed [SAMPLE_W-1:0] l;
		logic signed [SAMPLE_W-1:0] r;
		logic [CFG_W-1:0] gm;
		logic [CFG_W-1:0] pk;
		logic [CFG_W-1:0] rc;
		logic [CFG_W-1:0] rs;
		logic [CFG_W-1:0] fs;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		sample_left    = '0;
		sample_right   = '0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		long_hold_req  = 1'b0;
		sender_no_gaps = 1'b0;
		frames_sent    = 0;
		settings_used  = 1;
		level_shift    = SAMPLE_W - 1;
		frame_style    = STYLE_RAW;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: floor edge, full scale, peak hold and decay
		offer_frame(0, 0);
		offer_frame(838, 0);
		offer_frame(839, -839);
		offer_frame($signed(SAMPLE_MIN), $signed(SAMPLE_MAX));
		offer_frame($signed(SAMPLE_MAX), $signed(SAMPLE_MAX));
		offer_frame($signed(SAMPLE_MIN), $signed(SAMPLE_MIN));
		offer_frame(0, 0);
		offer_frame(1, -1);
		offer_frame(4194304, -4194304);
		offer_frame(-1, 0);
		offer_frame($signed(SAMPLE_MAX), $signed(SAMPLE_MIN));
		offer_frame(100000, 200000);
		in_valid <= 1'b0;
		wait_drained();

		// instant release, full steps, ceiling gain: fast climb then saturation
		apply_setting(GAIN_CEIL, CFG_W'(RST_PEAK), '0, GAIN_ONE, GAIN_ONE);
		repeat (5) offer_frame(1000, 1000);
		offer_frame($signed(SAMPLE_MAX), $signed(SAMPLE_MIN));
		offer_frame($signed(SAMPLE_MIN), $signed(SAMPLE_MAX));
		offer_frame(0, 0);
		offer_frame(839, 839);
		offer_frame(-839, 0);
		in_valid <= 1'b0;
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: apply_setting(GAIN_ONE, CFG_W'(PEAK_LOW), '0, '0, '0);
				1: apply_setting(GAIN_CEIL, CFG_W'(PEAK_HIGH), CFG_W'({COEFF_W{1'b1}}),
					GAIN_ONE, GAIN_ONE);
				2: begin
					// writes to unused indexes must change nothing
					for (int k = int'(REG_FALL) + 1; k < (1 << IDX_W); k++)
						write_reg(IDX_W'(k), CFG_W'($urandom));
					apply_setting(CFG_W'($urandom_range(0, GAIN_ONE - 1)),
						CFG_W'($urandom_range(0, PEAK_LOW - 1)), CFG_W'($urandom),
						CFG_W'($urandom_range(0, 512)), CFG_W'($urandom_range(0, 512)));
				end
				3: apply_setting('1, '1, '1, '1, '1);
				4: apply_setting(RST_MAX_GAIN, CFG_W'(RST_PEAK), CFG_W'(RST_RELEASE),
					CFG_W'(RST_RAISE), CFG_W'(RST_FALL));
				default: begin
					gm = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
						: CFG_W'($urandom_range(GAIN_ONE, GAIN_CEIL));
					pk = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
						: CFG_W'($urandom_range(PEAK_LOW, PEAK_HIGH));
					rc = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(60000, 65535))
						: CFG_W'($urandom);
					rs = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
						: CFG_W'($urandom_range(0, 4096));
					fs = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
						: CFG_W'($urandom_range(0, 4096));
					apply_setting(gm, pk, rc, rs, fs);
				end
			endcase
			long_hold_req  <= (p == HOLD_PHASE);
			sender_no_gaps <= (p == HOLD_PHASE);
			for (int i = 0; i < PHASE_FRAMES; i++) begin
				next_frame(l, r);
				offer_frame(l, r);
			end
			in_valid <= 1'b0;
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d stereo frames, checked %0d leveled frames", frames_sent, frames_checked);
		$display("used %0d register settings incl. reset defaults, range extremes and unused indexes",
			settings_used);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
